### sv/bftmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bftmr_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int COORD_W    = 16;
  localparam int AGE_W      = 8;
  localparam int AGE_KEEP_W = 4;
  localparam int STRENGTH_W = 32;
  localparam int CAP_W      = 5;
  localparam int SLOT_W     = 4;
  localparam int OCC_W      = 5;
  localparam int ENTRY_W    = 2 * COORD_W + AGE_KEEP_W + STRENGTH_W;

  localparam logic [AGE_W-1:0] AGE_LIMIT     = AGE_W'(10);
  localparam logic [CAP_W-1:0] CAP_RESET     = CAP_W'(16);
  localparam logic [CAP_W-1:0] CAP_MAX       = CAP_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_OLD     = 2'd2,
    ACT_OFF     = 2'd3
  } action_t;

  // micro-operations driving the datapath
  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_DISPATCH,
    OP_SCAN,
    OP_DRAIN,
    OP_WRITE,
    OP_EMIT
  } op_t;

  // conditions that hold the step counter where it is
  typedef enum logic [1:0] {
    H_NONE,
    H_NO_ITEM,
    H_SCAN_MORE,
    H_OUT_BUSY
  } hold_t;

  typedef enum logic [1:0] {
    J_NEVER,
    J_ALWAYS,
    J_NOT_REPLACE
  } jump_t;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_ACCEPT   = 3'd0;
  localparam step_t STEP_DISPATCH = 3'd1;
  localparam step_t STEP_SCAN     = 3'd2;
  localparam step_t STEP_DRAIN    = 3'd3;
  localparam step_t STEP_WRITE    = 3'd4;
  localparam step_t STEP_EMIT     = 3'd5;

  typedef struct packed {
    op_t   op;
    hold_t hold;
    jump_t jump;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_item;
    logic scan_more;
    logic out_busy;
    logic replace;
  } seq_status_t;

  // microprogram store
  function automatic ctrl_word_t program_rom(input step_t step);
    ctrl_word_t w;
    begin
      case (step)
        STEP_ACCEPT:   w = '{OP_ACCEPT,   H_NO_ITEM,   J_NEVER,       STEP_ACCEPT};
        STEP_DISPATCH: w = '{OP_DISPATCH, H_NONE,      J_NOT_REPLACE, STEP_WRITE};
        STEP_SCAN:     w = '{OP_SCAN,     H_SCAN_MORE, J_NEVER,       STEP_SCAN};
        STEP_DRAIN:    w = '{OP_DRAIN,    H_NONE,      J_NEVER,       STEP_DRAIN};
        STEP_WRITE:    w = '{OP_WRITE,    H_NONE,      J_NEVER,       STEP_WRITE};
        STEP_EMIT:     w = '{OP_EMIT,     H_OUT_BUSY,  J_ALWAYS,      STEP_ACCEPT};
        default:       w = '{OP_ACCEPT,   H_NONE,      J_ALWAYS,      STEP_ACCEPT};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

### sv/bftmr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bftmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/bftmr_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bftmr_seq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire bftmr_pkg::seq_status_t  status,
  output bftmr_pkg::ctrl_word_t        ctrl
);

  bftmr_pkg::step_t step_r;
  bftmr_pkg::step_t step_nxt;
  logic             hold;
  logic             jump;

  always_comb begin
    ctrl = bftmr_pkg::program_rom(step_r);
  end

  always_comb begin
    case (ctrl.hold)
      bftmr_pkg::H_NO_ITEM:   hold = status.no_item;
      bftmr_pkg::H_SCAN_MORE: hold = status.scan_more;
      bftmr_pkg::H_OUT_BUSY:  hold = status.out_busy;
      default:                hold = 1'b0;
    endcase
    case (ctrl.jump)
      bftmr_pkg::J_ALWAYS:      jump = 1'b1;
      bftmr_pkg::J_NOT_REPLACE: jump = !status.replace;
      default:                  jump = 1'b0;
    endcase
    if (hold) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_r + bftmr_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bftmr_pkg::STEP_ACCEPT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/bounded_feature_table_min_replace_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// steps: append or drop passes through the accept, dispatch, write and emit steps; replace also
//   runs the scan and drain steps between dispatch and write, scanning up to 16 filled entries
// throughput: a new transaction is taken only in the accept step, after the last one is emitted;
//   the weakest-entry scan reads one stored strength per cycle; result stalls hold the emit step
// reset: synchronous active-low rst_n clears the step counter, fill count and output valid,
//   and sets capacity to 16; entry contents are not cleared and are only read once written

module bounded_feature_table_min_replace_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // configuration channel
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [bftmr_pkg::CAP_W-1:0]            cfg_data,
  // input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [bftmr_pkg::COORD_W-1:0]          in_x_coord,
  input  wire logic [bftmr_pkg::COORD_W-1:0]          in_y_coord,
  input  wire logic [bftmr_pkg::AGE_W-1:0]            in_feature_age,
  input  wire logic signed [bftmr_pkg::STRENGTH_W-1:0] in_feature_strength,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [1:0]                                  out_action,
  output logic [bftmr_pkg::SLOT_W-1:0]                out_slot_index,
  output logic [bftmr_pkg::OCC_W-1:0]                 out_occupancy
);

  localparam int IDX_W = bftmr_pkg::IDX_W;
  localparam int CNT_W = bftmr_pkg::CNT_W;
  localparam int SW    = bftmr_pkg::STRENGTH_W;

  bftmr_pkg::ctrl_word_t  ctrl;
  bftmr_pkg::seq_status_t status;

  // configuration register
  logic [bftmr_pkg::CAP_W-1:0] capacity_r;

  // item held for the current transaction
  logic [bftmr_pkg::COORD_W-1:0]    x_r;
  logic [bftmr_pkg::COORD_W-1:0]    y_r;
  logic [bftmr_pkg::AGE_KEEP_W-1:0] age_r;
  logic [SW-1:0]                    strength_r;
  bftmr_pkg::action_t               kind_r;
  bftmr_pkg::action_t               kind_nxt;
  logic [IDX_W-1:0]                 slot_r;

  // table occupancy
  logic [CNT_W-1:0] fill_count_r;

  // scan state
  logic [IDX_W-1:0]     scan_idx_r;
  logic [IDX_W-1:0]     last_idx;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic signed [SW-1:0] best_r;
  logic [IDX_W-1:0]     best_idx_r;

  // entry ram
  logic                               ram_we;
  logic [IDX_W-1:0]                   ram_waddr;
  logic [bftmr_pkg::ENTRY_W-1:0]      ram_wdata;
  logic                               ram_re;
  logic [bftmr_pkg::ENTRY_W-1:0]      ram_rdata;
  logic signed [SW-1:0]               rd_strength;

  // output register
  logic                         out_valid_r;
  logic [1:0]                   out_action_r;
  logic [bftmr_pkg::SLOT_W-1:0] out_slot_r;
  logic [bftmr_pkg::OCC_W-1:0]  out_occ_r;

  logic in_take;
  logic out_busy;
  logic [bftmr_pkg::CAP_W-1:0] limit;

  // ---------------------------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------------------------
  bftmr_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  assign out_busy  = out_valid_r && out_stall;
  assign last_idx  = IDX_W'(fill_count_r - CNT_W'(1));

  always_comb begin
    status.no_item   = !in_valid;
    status.scan_more = (scan_idx_r != last_idx);
    status.out_busy  = out_busy;
    status.replace   = (kind_r == bftmr_pkg::ACT_REPLACE);
  end

  // ---------------------------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------------------------
  // input only taken in the accept step and out of reset
  assign in_stall  = !rst_n || (ctrl.op != bftmr_pkg::OP_ACCEPT);
  assign in_take   = in_valid && !in_stall;
  // capacity only taken between items, with nothing offered on the input
  assign cfg_ready = rst_n && (ctrl.op == bftmr_pkg::OP_ACCEPT) && !in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= bftmr_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // classify the incoming feature
  // ---------------------------------------------------------------------------------------------
  // capacity above the table depth saturates at the depth
  assign limit = (capacity_r > bftmr_pkg::CAP_MAX) ? bftmr_pkg::CAP_MAX : capacity_r;

  always_comb begin
    if (capacity_r == '0) begin
      kind_nxt = bftmr_pkg::ACT_OFF;            // zero capacity wins over age
    end else if (in_feature_age >= bftmr_pkg::AGE_LIMIT) begin
      kind_nxt = bftmr_pkg::ACT_OLD;
    end else if (bftmr_pkg::CAP_W'(fill_count_r) < limit) begin
      kind_nxt = bftmr_pkg::ACT_APPEND;
    end else begin
      kind_nxt = bftmr_pkg::ACT_REPLACE;        // full, or capacity lowered below fill
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r        <= in_x_coord;
      y_r        <= in_y_coord;
      age_r      <= in_feature_age[bftmr_pkg::AGE_KEEP_W-1:0];
      strength_r <= in_feature_strength;
      kind_r     <= kind_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // weakest-entry scan: one ram read per cycle, each compared in the cycle after its read, not later
  // ---------------------------------------------------------------------------------------------
  assign ram_re      = (ctrl.op == bftmr_pkg::OP_SCAN);
  assign rd_strength = ram_rdata[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == bftmr_pkg::OP_DISPATCH) begin
      scan_idx_r <= '0;
    end else if (ram_re) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    if (ram_re) begin
      cmp_idx_r <= scan_idx_r;
    end
    // strict less-than keeps the first minimum on a tie
    if (cmp_vld_r && ((cmp_idx_r == '0) || (rd_strength < best_r))) begin
      best_r     <= rd_strength;
      best_idx_r <= cmp_idx_r;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // entry write and fill count
  // ---------------------------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx_r;
    if (ctrl.op == bftmr_pkg::OP_WRITE) begin
      case (kind_r)
        bftmr_pkg::ACT_APPEND: begin
          ram_we    = 1'b1;
          ram_waddr = fill_count_r[IDX_W-1:0];
        end
        bftmr_pkg::ACT_REPLACE: begin
          ram_we    = 1'b1;
          ram_waddr = best_idx_r;
        end
        default: begin
          ram_we    = 1'b0;
        end
      endcase
    end
  end

  assign ram_wdata = {x_r, y_r, age_r, strength_r};

  bftmr_ram #(
    .WIDTH (bftmr_pkg::ENTRY_W),
    .DEPTH (bftmr_pkg::TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
    end else if (ram_we && (kind_r == bftmr_pkg::ACT_APPEND)) begin
      fill_count_r <= fill_count_r + CNT_W'(1);
    end
  end

  // slot reported: zero for drops, the written entry otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      slot_r <= '0;
    end else if (ram_we) begin
      slot_r <= ram_waddr;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctrl.op == bftmr_pkg::OP_EMIT) && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == bftmr_pkg::OP_EMIT) && !out_busy) begin
      out_action_r <= kind_r;
      out_slot_r   <= bftmr_pkg::SLOT_W'(slot_r);
      out_occ_r    <= bftmr_pkg::OCC_W'(fill_count_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_slot_index = out_slot_r;
  assign out_occupancy  = out_occ_r;

  // ---------------------------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------------------------
  // the table never holds more entries than it has
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(bftmr_pkg::TABLE_DEPTH))
    else $error("fill count above table depth");

  // the fill count only ever steps up by one
  a_fill_step : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(fill_count_r)) |->
      (fill_count_r == $past(fill_count_r) + CNT_W'(1)))
    else $error("fill count changed by other than one");

  // the scan only compares entries that have been written
  a_scan_filled : assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (CNT_W'(cmp_idx_r) < fill_count_r))
    else $error("scan read an unfilled entry");

  // a replace always writes the entry the scan picked
  a_replace_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (kind_r == bftmr_pkg::ACT_REPLACE)) |-> (ram_waddr == best_idx_r))
    else $error("replace wrote other than the weakest entry");

endmodule

`default_nettype wire
